@@ sv/gcps_pkg.sv @@
// Shared types and constants for the game-pad config/poll sequencer.
// Holds the phase encoding, the fixed configuration frame bytes and the
// structs passed between the register file, the step logic and the top level.
package gcps_pkg;

    typedef enum logic [2:0] {
        PH_PROBE    = 3'd0,
        PH_ENTER    = 3'd1,
        PH_ANALOG   = 3'd2,
        PH_MOTOR    = 3'd3,
        PH_PRESSURE = 3'd4,
        PH_EXIT     = 3'd5,
        PH_POLL     = 3'd6
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SMALL_MOTOR = 2'd0;
    localparam logic [1:0] REG_LARGE_MOTOR = 2'd1;
    localparam logic [1:0] REG_SKIP_FAILS  = 2'd2;
    localparam logic [1:0] REG_RESYNC_FAILS = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [2:0] SKIP_FAILS_RST   = 3'd3;
    localparam logic [2:0] RESYNC_FAILS_RST = 3'd5;
    localparam logic [2:0] FAIL_CNT_MAX     = 3'd7;

    // Frame lengths in bytes: probe/enter are short, the rest of config is long
    localparam int SHORT_FRAME_LEN = 5;
    localparam int CFG_FRAME_LEN   = 9;

    localparam logic [7:0] BYTE_START    = 8'h01;
    localparam logic [7:0] BYTE_POLL     = 8'h42;
    localparam logic [7:0] BYTE_ACK      = 8'h5A;
    localparam logic [7:0] BYTE_CFG_ID   = 8'hF3;
    localparam logic [7:0] BYTE_MOTOR_OK = 8'h01;
    localparam logic [7:0] PRESSURE_MASK = 8'h73;

    localparam logic [7:0] CFG_FRAMES [0:5][0:8] = '{
        '{8'h01, 8'h42, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'h01, 8'h4F, 8'h00, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
    };

    typedef struct packed {
        logic [7:0] small_motor;
        logic [7:0] large_motor;
        logic [2:0] skip_fails;
        logic [2:0] resync_fails;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] fail_cnt;
        logic       active;
        logic       check_ok;
    } seq_state_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       attention;
        logic       frame_done;
        logic [7:0] pad_data;
        logic       pad_data_valid;
        logic       pad_data_last;
        phase_t     phase;
        logic       hard_resync;
    } result_t;

    // Fixed command byte of a configuration frame; zero past the table
    function automatic logic [7:0] cfg_cmd_byte(phase_t ph, logic [3:0] pos);
        logic [7:0] b;
        b = 8'h00;
        if (ph != PH_POLL && ph <= PH_EXIT && pos < 4'(CFG_FRAME_LEN))
        begin
            b = CFG_FRAMES[ph][pos];
        end
        return b;
    endfunction

endpackage

@@ sv/gcps_cfg_regs.sv @@
// Configuration register file of the game-pad sequencer.
// Motor levels and failure thresholds; depends on gcps_pkg.
module gcps_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [gcps_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [gcps_pkg::CFG_DATA_W-1:0]  wr_data,
    output gcps_pkg::cfg_t                 cfg
);
    import gcps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SMALL_MOTOR:  cfg_next.small_motor  = wr_data;
                REG_LARGE_MOTOR:  cfg_next.large_motor  = wr_data;
                REG_SKIP_FAILS:   cfg_next.skip_fails   = wr_data[2:0];
                REG_RESYNC_FAILS: cfg_next.resync_fails = wr_data[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_motor  <= 8'h00;
            cfg_reg.large_motor  <= 8'h00;
            cfg_reg.skip_fails   <= SKIP_FAILS_RST;
            cfg_reg.resync_fails <= RESYNC_FAILS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/gcps_step.sv @@
// Per-beat decision logic of the game-pad sequencer: next command byte,
// reply checks, frame end and phase/failure bookkeeping. Depends on gcps_pkg.
module gcps_step #(
    parameter int POLL_LENGTH = 21,
    parameter int POS_W       = 5
) (
    input  logic                   cmd,
    input  logic [7:0]             rx_byte,
    input  gcps_pkg::seq_state_t   st,
    input  logic [POS_W-1:0]       pos,
    input  gcps_pkg::cfg_t         cfg,
    output gcps_pkg::seq_state_t   st_next,
    output logic [POS_W-1:0]       pos_next,
    output gcps_pkg::result_t      res
);
    import gcps_pkg::*;

    localparam logic [POS_W:0] LEN_SHORT = (POS_W+1)'(SHORT_FRAME_LEN);
    localparam logic [POS_W:0] LEN_CFG   = (POS_W+1)'(CFG_FRAME_LEN);
    localparam logic [POS_W:0] LEN_POLL  = (POS_W+1)'(POLL_LENGTH);
    localparam logic [POS_W:0] POS_SMALL = (POS_W+1)'(3);
    localparam logic [POS_W:0] POS_LARGE = (POS_W+1)'(4);

    function automatic logic reply_ok(phase_t ph, logic [POS_W-1:0] p, logic [7:0] rx);
        logic ok;
        ok = 1'b1;
        case (ph)
            PH_PROBE, PH_ENTER:
            begin
                if (p == POS_W'(2)) ok = (rx == BYTE_ACK);
            end
            PH_ANALOG, PH_EXIT:
            begin
                if (p == POS_W'(1)) ok = (rx == BYTE_CFG_ID);
                if (p == POS_W'(2)) ok = (rx == BYTE_ACK);
            end
            PH_MOTOR:
            begin
                if (p == POS_W'(1)) ok = (rx == BYTE_CFG_ID);
                if (p == POS_W'(2)) ok = (rx == BYTE_ACK);
                if (p == POS_W'(4)) ok = (rx == BYTE_MOTOR_OK);
            end
            PH_PRESSURE:
            begin
                if (p == POS_W'(1)) ok = ((rx & PRESSURE_MASK) != 8'h00);
            end
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    logic             polling;
    logic [POS_W:0]   frame_len;
    logic [POS_W:0]   pos_inc;
    logic [POS_W:0]   tx_pos;
    logic [7:0]       tx_sel;
    logic             ok_all;
    logic [2:0]       fail_inc;

    assign polling = (st.phase == PH_POLL);

    always_comb
    begin
        case (st.phase)
            PH_PROBE, PH_ENTER: frame_len = LEN_SHORT;
            PH_POLL:            frame_len = LEN_POLL;
            default:            frame_len = LEN_CFG;
        endcase
    end

    assign pos_inc  = {1'b0, pos} + 1'b1;
    assign tx_pos   = cmd ? pos_inc : '0;
    assign ok_all   = st.check_ok & (polling | reply_ok(st.phase, pos, rx_byte));
    assign fail_inc = (st.fail_cnt == FAIL_CNT_MAX) ? FAIL_CNT_MAX : st.fail_cnt + 3'd1;

    // Command byte for the byte that goes out after this beat
    always_comb
    begin
        if (polling)
        begin
            if (tx_pos == '0)
                tx_sel = BYTE_START;
            else if (tx_pos == (POS_W+1)'(1))
                tx_sel = BYTE_POLL;
            else if (tx_pos == POS_SMALL)
                tx_sel = cfg.small_motor;
            else if (tx_pos == POS_LARGE)
                tx_sel = cfg.large_motor;
            else
                tx_sel = 8'h00;
        end
        else if (tx_pos < LEN_CFG)
        begin
            tx_sel = cfg_cmd_byte(st.phase, tx_pos[3:0]);
        end
        else
        begin
            tx_sel = 8'h00;
        end
    end

    always_comb
    begin
        st_next  = st;
        pos_next = pos;
        res      = '0;

        if (!cmd)
        begin
            if (!st.active)
            begin
                st_next.active   = 1'b1;
                st_next.check_ok = 1'b1;
                pos_next         = '0;
                res.tx_byte      = tx_sel;
                res.tx_valid     = 1'b1;
            end
        end
        else if (st.active)
        begin
            if (polling)
            begin
                res.pad_data       = rx_byte;
                res.pad_data_valid = 1'b1;
            end
            st_next.check_ok = ok_all;

            if (pos_inc < frame_len)
            begin
                pos_next     = pos_inc[POS_W-1:0];
                res.tx_byte  = tx_sel;
                res.tx_valid = 1'b1;
            end
            else
            begin
                st_next.active   = 1'b0;
                st_next.check_ok = 1'b1;
                pos_next         = '0;
                res.frame_done   = 1'b1;
                if (polling)
                begin
                    res.pad_data_last = 1'b1;
                end
                else if (ok_all)
                begin
                    st_next.phase    = phase_t'(st.phase + 3'd1);
                    st_next.fail_cnt = 3'd0;
                end
                else if ((st.phase == PH_ANALOG || st.phase == PH_MOTOR) &&
                         fail_inc >= cfg.skip_fails)
                begin
                    // optional phase given up on
                    st_next.phase    = phase_t'(st.phase + 3'd1);
                    st_next.fail_cnt = 3'd0;
                end
                else if (fail_inc >= cfg.resync_fails)
                begin
                    st_next.phase    = PH_PROBE;
                    st_next.fail_cnt = 3'd0;
                    res.hard_resync  = 1'b1;
                end
                else
                begin
                    st_next.fail_cnt = fail_inc;
                end
            end
        end

        res.attention = st_next.active;
        res.phase     = st_next.phase;
    end

endmodule

@@ sv/gcps_top_placeholder_unused.sv @@
// Game-pad sequencer state register stage.
// Holds the protocol state and byte position; depends on gcps_pkg.
module gcps_state_regs #(
    parameter int POS_W = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  gcps_pkg::seq_state_t st_next,
    input  logic [POS_W-1:0]     pos_next,
    output gcps_pkg::seq_state_t st,
    output logic [POS_W-1:0]     pos
);
    import gcps_pkg::*;

    seq_state_t       st_reg;
    logic [POS_W-1:0] pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase    <= PH_PROBE;
            st_reg.fail_cnt <= 3'd0;
            st_reg.active   <= 1'b0;
            st_reg.check_ok <= 1'b1;
            pos_reg         <= '0;
        end
        else if (en)
        begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

    assign st  = st_reg;
    assign pos = pos_reg;

endmodule

@@ sv/gamepad_config_and_poll_sequencer.sv @@
// Game-pad host protocol sequencer. Each beat on the input channel (a poll tick
// or one reply byte) yields exactly one result beat carrying the next command
// byte and status. Beats enter an input register, the decision logic runs over
// that register and the protocol state, and the result lands in an output
// register. One beat is taken every cycle unless out_ready stalls a full output
// register, since the phase/position state updates in the same cycle the result
// is registered. The input side keeps accepting while a result waits unless both
// registers are full. Configuration writes are taken at any time (cfg_ready is
// always high) but are meant to be issued only while no beat is in flight.
// Depends on gcps_pkg, gcps_cfg_regs, gcps_step and gcps_state_regs.
module gamepad_config_and_poll_sequencer #(
    parameter int POLL_LENGTH = 21
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       tx_byte,
    output logic                             tx_valid,
    output logic                             attention,
    output logic                             frame_done,
    output logic [7:0]                       pad_data,
    output logic                             pad_data_valid,
    output logic                             pad_data_last,
    output logic [2:0]                       phase,
    output logic                             hard_resync,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gcps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gcps_pkg::*;

    localparam int FRAME_MAX = (POLL_LENGTH > CFG_FRAME_LEN) ? POLL_LENGTH : CFG_FRAME_LEN;
    localparam int POS_W     = $clog2(FRAME_MAX);

    cfg_t             cfg;
    seq_state_t       st;
    seq_state_t       st_next;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_next;
    result_t          res;

    logic       in_valid_reg;
    logic       cmd_reg;
    logic [7:0] rx_byte_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    logic       advance;

    assign cfg_ready = 1'b1;

    gcps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Beat moves from the input register to the result register
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg     <= cmd;
            rx_byte_reg <= rx_byte;
        end
    end

    gcps_step #(
        .POLL_LENGTH (POLL_LENGTH),
        .POS_W       (POS_W)
    ) u_step (
        .cmd      (cmd_reg),
        .rx_byte  (rx_byte_reg),
        .st       (st),
        .pos      (pos),
        .cfg      (cfg),
        .st_next  (st_next),
        .pos_next (pos_next),
        .res      (res)
    );

    gcps_state_regs #(
        .POS_W (POS_W)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .st_next  (st_next),
        .pos_next (pos_next),
        .st       (st),
        .pos      (pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tx_byte        = res_reg.tx_byte;
    assign tx_valid       = res_reg.tx_valid;
    assign attention      = res_reg.attention;
    assign frame_done     = res_reg.frame_done;
    assign pad_data       = res_reg.pad_data;
    assign pad_data_valid = res_reg.pad_data_valid;
    assign pad_data_last  = res_reg.pad_data_last;
    assign phase          = res_reg.phase;
    assign hard_resync    = res_reg.hard_resync;

    // A finished frame closes the select line
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !attention)
        else $error("frame_done with attention still high");

    // Reply bytes are forwarded only while polling
    a_pad_in_poll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pad_data_valid |-> phase == PH_POLL)
        else $error("pad_data_valid outside poll phase");

    // Resync lands in the probe phase at a frame end
    a_resync_probe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hard_resync |-> (phase == PH_PROBE && frame_done))
        else $error("hard_resync without return to probe");

    // Stalled beat in the input register is not dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cmd_reg))
        else $error("input register lost a stalled beat");

    // State only moves when a beat is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st) && $stable(pos))
        else $error("sequencer state changed without a beat");

endmodule

@@ verif/tb_gamepad_config_and_poll_sequencer.sv @@
// Self-checking testbench for gamepad_config_and_poll_sequencer: drives ticks and reply
// bytes, predicts every result beat and compares it field by field.
// Depends on gcps_pkg and the sequencer RTL only.
module tb_gamepad_config_and_poll_sequencer;
    import gcps_pkg::*;

    localparam int POLL_LEN = 21;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    // Command bytes of the six configuration frames
    localparam logic [7:0] FRAME_BYTES [6][9] = '{
        '{8'h01, 8'h42, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'h01, 8'h4F, 8'h00, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       attention;
    logic       frame_done;
    logic [7:0] pad_data;
    logic       pad_data_valid;
    logic       pad_data_last;
    logic [2:0] phase;
    logic       hard_resync;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted protocol state and register copies
    phase_t     cur_phase;
    logic [2:0] fail_count;
    int         byte_pos;
    bit         frame_open;
    bit         replies_ok;
    logic [7:0] small_motor_lvl;
    logic [7:0] large_motor_lvl;
    logic [2:0] skip_limit;
    logic [2:0] resync_limit;

    result_t sequencer_results_due[$];
    int      mismatch_count;
    int      sender_gap_max;
    int      sink_gap_max;
    int      sink_hold;

    gamepad_config_and_poll_sequencer #(.POLL_LENGTH(POLL_LEN)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .tx_valid       (tx_valid),
        .attention      (attention),
        .frame_done     (frame_done),
        .pad_data       (pad_data),
        .pad_data_valid (pad_data_valid),
        .pad_data_last  (pad_data_last),
        .phase          (phase),
        .hard_resync    (hard_resync),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int frame_len(phase_t ph);
        if (ph < PH_ANALOG)
            return SHORT_FRAME_LEN;
        if (ph != PH_POLL)
            return CFG_FRAME_LEN;
        return POLL_LEN;
    endfunction

    function automatic logic [7:0] command_for(phase_t ph, int pos);
        if (ph != PH_POLL)
            return (pos < CFG_FRAME_LEN) ? FRAME_BYTES[ph][pos] : 8'h00;
        case (pos)
            0: return BYTE_START;
            1: return BYTE_POLL;
            3: return small_motor_lvl;
            4: return large_motor_lvl;
            default: return 8'h00;
        endcase
    endfunction

    function automatic bit reply_acceptable(phase_t ph, int pos, logic [7:0] rx);
        case (ph)
            PH_PROBE, PH_ENTER:
                return pos != 2 || rx == BYTE_ACK;
            PH_ANALOG, PH_EXIT:
            begin
                if (pos == 1)
                    return rx == BYTE_CFG_ID;
                if (pos == 2)
                    return rx == BYTE_ACK;
                return 1'b1;
            end
            PH_MOTOR:
            begin
                if (pos == 1)
                    return rx == BYTE_CFG_ID;
                if (pos == 2)
                    return rx == BYTE_ACK;
                if (pos == 4)
                    return rx == BYTE_MOTOR_OK;
                return 1'b1;
            end
            PH_PRESSURE:
                return pos != 1 || (rx & PRESSURE_MASK) != 8'h00;
            default:
                return 1'b1;
        endcase
    endfunction

    // Advances the predicted state by one accepted beat and returns its result
    function automatic result_t next_sequencer_result(logic c, logic [7:0] rx);
        result_t r;
        phase_t  ph;
        int      pos;
        bit      skipped;
        r = '0;
        ph = cur_phase;
        if (c == CMD_TICK)
        begin
            if (!frame_open)
            begin
                frame_open = 1'b1;
                byte_pos = 0;
                replies_ok = 1'b1;
                r.tx_byte = command_for(ph, 0);
                r.tx_valid = 1'b1;
            end
        end
        else if (frame_open)
        begin
            pos = byte_pos;
            if (ph == PH_POLL)
            begin
                r.pad_data = rx;
                r.pad_data_valid = 1'b1;
            end
            else if (!reply_acceptable(ph, pos, rx))
                replies_ok = 1'b0;
            pos++;
            if (pos < frame_len(ph))
            begin
                byte_pos = pos;
                r.tx_byte = command_for(ph, pos);
                r.tx_valid = 1'b1;
            end
            else
            begin
                frame_open = 1'b0;
                byte_pos = 0;
                r.frame_done = 1'b1;
                if (ph == PH_POLL)
                    r.pad_data_last = 1'b1;
                else if (replies_ok)
                begin
                    cur_phase = phase_t'(ph + 1);
                    fail_count = 3'd0;
                end
                else
                begin
                    skipped = 1'b0;
                    if (fail_count != FAIL_CNT_MAX)
                        fail_count++;
                    // optional phases are passed over once failures pile up
                    if ((ph == PH_ANALOG || ph == PH_MOTOR) && fail_count >= skip_limit)
                    begin
                        cur_phase = phase_t'(ph + 1);
                        fail_count = 3'd0;
                        skipped = 1'b1;
                    end
                    if (!skipped && fail_count >= resync_limit)
                    begin
                        cur_phase = PH_PROBE;
                        fail_count = 3'd0;
                        r.hard_resync = 1'b1;
                    end
                end
                replies_ok = 1'b1;
            end
        end
        r.attention = frame_open;
        r.phase = cur_phase;
        return r;
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("tx %h/%b att %b done %b pad %h/%b/%b ph %0d rs %b",
            r.tx_byte, r.tx_valid, r.attention, r.frame_done, r.pad_data,
            r.pad_data_valid, r.pad_data_last, r.phase, r.hard_resync);
    endfunction

    // Called at the rising edge after the previous beat; returns at the accepting edge
    task automatic send_beat(input logic c, input logic [7:0] b);
        int gap;
        gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        rx_byte <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        sequencer_results_due.push_back(next_sequencer_result(c, b));
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        in_valid <= 1'b0;
        while (sequencer_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        case (idx)
            REG_SMALL_MOTOR:  small_motor_lvl = val;
            REG_LARGE_MOTOR:  large_motor_lvl = val;
            REG_SKIP_FAILS:   skip_limit = val[2:0];
            REG_RESYNC_FAILS: resync_limit = val[2:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One whole frame in the current phase; spoil puts one bad byte at a checked spot
    task automatic run_frame(input bit spoil);
        phase_t     ph;
        int         bad_pos;
        logic [7:0] b;
        ph = cur_phase;
        bad_pos = -1;
        if (spoil && ph != PH_POLL)
        begin
            do
                bad_pos = $urandom_range(1, 4);
            while (reply_acceptable(ph, bad_pos, 8'h00));
        end
        send_beat(CMD_TICK, 8'($urandom));
        for (int p = 0; p < frame_len(ph); p++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(CMD_TICK, 8'($urandom));
            if (p == bad_pos)
            begin
                do
                    b = 8'($urandom);
                while (reply_acceptable(ph, p, b));
            end
            else
            begin
                do
                    b = 8'($urandom);
                while (!reply_acceptable(ph, p, b));
            end
            send_beat(CMD_REPLY, b);
        end
        if ($urandom_range(0, 7) == 0)
            send_beat(CMD_REPLY, 8'($urandom));
    endtask

    task automatic test_directed_edges();
        send_beat(CMD_REPLY, 8'h00);
        send_beat(CMD_REPLY, 8'hFF);
        send_beat(CMD_TICK, 8'hFF);
        send_beat(CMD_TICK, 8'h00);
        // probe frame with a bad ack byte
        send_beat(CMD_REPLY, 8'hFF);
        send_beat(CMD_REPLY, 8'hFF);
        send_beat(CMD_REPLY, 8'h00);
        send_beat(CMD_REPLY, 8'h00);
        send_beat(CMD_REPLY, 8'hFF);
        send_beat(CMD_REPLY, 8'h00);
        // clean probe frame
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_REPLY, 8'h00);
        send_beat(CMD_REPLY, 8'h00);
        send_beat(CMD_REPLY, BYTE_ACK);
        send_beat(CMD_REPLY, 8'hFF);
        send_beat(CMD_REPLY, 8'hFF);
        send_beat(CMD_TICK, 8'h5A);
        send_beat(CMD_REPLY, 8'hFF);
    endtask

    task automatic test_failure_thresholds();
        int skip_set [8] = '{3, 1, 7, 0, 1, 7, 2, 4};
        int resync_set [8] = '{5, 1, 7, 0, 7, 1, 4, 2};
        bit spoil;
        for (int s = 0; s < 8; s++)
        begin
            write_reg(REG_SKIP_FAILS, 8'(skip_set[s]));
            write_reg(REG_RESYNC_FAILS, 8'(resync_set[s]));
            sender_gap_max = (s % 3 == 1) ? 0 : 13;
            sink_gap_max = (s % 3 == 2) ? 0 : 13;
            for (int f = 0; f < 15; f++)
            begin
                // never let the exit frame pass here: polling has no way back
                spoil = (cur_phase == PH_EXIT) || ($urandom_range(0, 2) == 0);
                run_frame(spoil);
            end
        end
        sender_gap_max = 13;
        sink_gap_max = 13;
    endtask

    task automatic test_polling();
        logic [7:0] small_set [6] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
        logic [7:0] large_set [6] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
        write_reg(REG_SKIP_FAILS, 8'(SKIP_FAILS_RST));
        write_reg(REG_RESYNC_FAILS, 8'(RESYNC_FAILS_RST));
        while (cur_phase != PH_POLL)
            run_frame(1'b0);
        for (int m = 0; m < 6; m++)
        begin
            if (m >= 4)
            begin
                small_set[m] = 8'($urandom);
                large_set[m] = 8'($urandom);
            end
            write_reg(REG_SMALL_MOTOR, small_set[m]);
            write_reg(REG_LARGE_MOTOR, large_set[m]);
            for (int f = 0; f < 4; f++)
                run_frame(1'b0);
        end
    endtask

    task automatic test_backpressure();
        sender_gap_max = 0;
        sink_hold = 300;
        for (int f = 0; f < 4; f++)
            run_frame(1'b0);
        sender_gap_max = 13;
    endtask

    // Result side: random stalls, long hold on request, compare each beat
    initial
    begin
        result_t seen;
        result_t want;
        int      stall;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            stall = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            seen.tx_byte = tx_byte;
            seen.tx_valid = tx_valid;
            seen.attention = attention;
            seen.frame_done = frame_done;
            seen.pad_data = pad_data;
            seen.pad_data_valid = pad_data_valid;
            seen.pad_data_last = pad_data_last;
            seen.phase = phase_t'(phase);
            seen.hard_resync = hard_resync;
            if (sequencer_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: %s", describe(seen));
            end
            else
            begin
                want = sequencer_results_due.pop_front();
                if (seen.tx_byte !== want.tx_byte || seen.tx_valid !== want.tx_valid
                    || seen.attention !== want.attention
                    || seen.frame_done !== want.frame_done
                    || seen.pad_data !== want.pad_data
                    || seen.pad_data_valid !== want.pad_data_valid
                    || seen.pad_data_last !== want.pad_data_last
                    || seen.phase !== want.phase
                    || seen.hard_resync !== want.hard_resync)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch at %0t: exp %s | got %s", $time,
                            describe(want), describe(seen));
                end
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_SMALL_MOTOR;
        cfg_data = 8'h00;
        mismatch_count = 0;
        sender_gap_max = 13;
        sink_gap_max = 13;
        sink_hold = 0;
        cur_phase = PH_PROBE;
        fail_count = 3'd0;
        byte_pos = 0;
        frame_open = 1'b0;
        replies_ok = 1'b1;
        small_motor_lvl = 8'h00;
        large_motor_lvl = 8'h00;
        skip_limit = SKIP_FAILS_RST;
        resync_limit = RESYNC_FAILS_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_failure_thresholds();
        test_polling();
        test_backpressure();

        in_valid <= 1'b0;
        while (sequencer_results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sequencer_results_due.size() != 0)
            mismatch_count += sequencer_results_due.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/gcps_pkg.sv
sv/gcps_cfg_regs.sv
sv/gcps_step.sv
sv/gcps_top_placeholder_unused.sv
sv/gamepad_config_and_poll_sequencer.sv
verif/tb_gamepad_config_and_poll_sequencer.sv
